/* hw/rtl/gtm_pkg.sv */
// Package with shared types, constants and register indexes of the gamepad-to-mouse mapper.
`timescale 1ns / 1ps
package gtm_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int ACC_W = FRACTION_BITS + 1;
  localparam int DIV_DW = 32 + FRACTION_BITS;
  localparam int DIV_CW = $clog2(DIV_DW + 1);
  localparam int SUM_W = DIV_DW + 2;

  localparam logic [31:0] DEADZONE_SQ = 32'd24157717;
  localparam logic [31:0] NS_PER_S = 32'd1000000000;

  localparam logic [15:0] SENS_RESET = 16'd1200;
  localparam logic [9:0] FRAME_RATE_RESET = 10'd144;
  localparam logic [9:0] SCROLL_RATE_RESET = 10'd20;

  typedef enum logic [1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_FRAME_RATE = 2'd1,
    REG_MAX_SCROLL_RATE = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_PRESS = 2'd1,
    EV_RELEASE = 2'd2
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_MULX,
    ST_DIVX,
    ST_ACCX,
    ST_MULY,
    ST_DIVY,
    ST_ACCY,
    ST_DIVP,
    ST_DIVS,
    ST_DIVF,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic right_bumper;
    logic [7:0] right_trigger;
    logic button_a;
    logic button_b;
    logic button_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic [1:0] left_event;
    logic [1:0] right_event;
    logic [1:0] middle_event;
    logic [5:0] scroll_down_count;
    logic [5:0] scroll_up_count;
  } out_word_t;

endpackage

/* hw/rtl/gtm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions of the mapper.
`timescale 1ns / 1ps
module gtm_div
  import gtm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [31:0]       divisor_i,
  input  logic [DIV_CW-1:0] iters_i,
  output logic              done_o,
  output logic [DIV_DW-1:0] quotient_o,
  output logic [31:0]       remainder_o
);

  logic              active_q, active_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] dvd_q, dvd_d;
  logic [DIV_DW-1:0] quo_q, quo_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       dsr_q, dsr_d;
  logic [32:0]       rem_sh;
  logic [32:0]       diff;

  always_comb begin
    active_d = active_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    rem_sh = {rem_q, dvd_q[DIV_DW-1]};
    diff = rem_sh - {1'b0, dsr_q};
    if (start_i) begin
      active_d = 1'b1;
      cnt_d = iters_i;
      dvd_d = dividend_i;
      quo_d = '0;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (active_q) begin
      if (cnt_q != '0) begin
        dvd_d = {dvd_q[DIV_DW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (rem_sh >= {1'b0, dsr_q}) begin
          rem_d = diff[31:0];
          quo_d = {quo_q[DIV_DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = {quo_q[DIV_DW-2:0], 1'b0};
        end
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      active_q <= active_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = active_q && (cnt_q == '0);
  assign quotient_o = quo_q;
  assign remainder_o = rem_q;

endmodule

/* hw/rtl/gamepad_to_mouse_frame_mapper_unit.sv */
// Top level of the gamepad-to-mouse mapper: sequencer, shared multiplier and state.
// The shared one-bit-per-cycle divider dominates the time from the accepting edge to out_valid_o.
// Input is stalled while the sequencer is busy; a new word is taken while a result still waits.
// Reset: asynchronous, active low; clears accumulators, button history, hold timers
// and scroll time budget, and loads the register reset values.
`timescale 1ns / 1ps
module gamepad_to_mouse_frame_mapper_unit
  import gtm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [15:0] sens_q;
  logic [9:0]  fr_q, msr_q;
  logic [9:0]  fr_eff, msr_eff;

  logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
  logic [4:0]  prev_q;
  logic [15:0] hold_a_q, hold_b_q;
  logic [31:0] st_q;

  in_word_t    in_q;
  logic [16:0] xmag_q, ymag_q;
  logic        xneg_q, yneg_q;
  logic [33:0] prod_q;
  logic        dz_q;
  logic signed [15:0] mx_q, my_q;
  logic [31:0] period_q, n_q, strem_q;

  logic        out_valid_q;
  out_word_t   out_q;

  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;

  logic              div_start, div_done, div_pend_q, div_pend_d;
  logic [DIV_DW-1:0] div_dvd, div_quo;
  logic [31:0]       div_dsr, div_rem;
  logic [DIV_CW-1:0] div_iters;
  logic [24:0]       den;

  logic accept;
  logic fin_go;

  // Accumulator update for the axis being finished.
  logic                    acc_neg;
  logic signed [ACC_W-1:0] acc_cur, acc_new;
  logic signed [SUM_W-1:0] step_s, sum_s;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        whole_mag;
  logic [FRACTION_BITS-1:0] frac_mag;
  logic signed [15:0]      whole_sat;

  // Hold and scroll results.
  logic        a_i, b_i, a_prev, b_prev, trig;
  logic [15:0] hold_a_d, hold_b_d, hold_a_base;
  logic        long_a, long_b, long_b_old;
  logic [6:0]  down_sum, up_sum;
  logic [5:0]  n_sat;
  logic [31:0] st_d;
  out_word_t   res;

  function automatic logic is_long(input logic [15:0] h, input logic [9:0] f);
    logic [18:0] h5;
    logic [18:0] f3;
    h5 = {3'b000, h} + {1'b0, h, 2'b00};
    f3 = {9'd0, f} + {8'd0, f, 1'b0};
    return h5 > f3;
  endfunction

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [1:0] edge_code(input logic now, input logic was);
    if (now == was) return EV_NONE;
    return now ? EV_PRESS : EV_RELEASE;
  endfunction

  assign fr_eff = (fr_q == '0) ? 10'd1 : fr_q;
  assign msr_eff = (msr_q == '0) ? 10'd1 : msr_q;
  assign den = {fr_eff, 15'd0} - {15'd0, fr_eff};

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;

  // Shared multiplier.
  always_comb begin
    case (state_q)
      ST_SQX:  begin mul_a = xmag_q; mul_b = xmag_q; end
      ST_SQY:  begin mul_a = ymag_q; mul_b = ymag_q; end
      ST_MULX: begin mul_a = xmag_q; mul_b = {1'b0, sens_q}; end
      ST_MULY: begin mul_a = ymag_q; mul_b = {1'b0, sens_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider operand selection.
  always_comb begin
    case (state_q)
      ST_DIVX, ST_DIVY: begin
        div_dvd = {prod_q[31:0], {FRACTION_BITS{1'b0}}};
        div_dsr = {7'd0, den};
        div_iters = DIV_CW'(DIV_DW);
      end
      ST_DIVP: begin
        div_dvd = {NS_PER_S, {FRACTION_BITS{1'b0}}};
        div_dsr = {22'd0, msr_eff};
        div_iters = DIV_CW'(32);
      end
      ST_DIVS: begin
        div_dvd = {st_q, {FRACTION_BITS{1'b0}}};
        div_dsr = period_q;
        div_iters = DIV_CW'(32);
      end
      ST_DIVF: begin
        div_dvd = {NS_PER_S, {FRACTION_BITS{1'b0}}};
        div_dsr = {22'd0, fr_eff};
        div_iters = DIV_CW'(32);
      end
      default: begin
        div_dvd = '0;
        div_dsr = 32'd1;
        div_iters = '0;
      end
    endcase
  end

  gtm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .iters_i     (div_iters),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Step add and split into whole pixels and kept fraction.
  always_comb begin
    acc_neg = (state_q == ST_ACCX) ? xneg_q : yneg_q;
    acc_cur = (state_q == ST_ACCX) ? acc_x_q : acc_y_q;
    step_s = acc_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    sum_s = step_s + SUM_W'(acc_cur);
    sum_mag = sum_s[SUM_W-1] ? SUM_W'(-sum_s) : SUM_W'(sum_s);
    whole_mag = sum_mag >> FRACTION_BITS;
    frac_mag = sum_mag[FRACTION_BITS-1:0];
    acc_new = sum_s[SUM_W-1] ? -$signed({1'b0, frac_mag}) : $signed({1'b0, frac_mag});
    if (sum_s[SUM_W-1]) begin
      whole_sat = (whole_mag > SUM_W'(32768)) ? 16'sh8000 : -$signed(whole_mag[15:0]);
    end else begin
      whole_sat = (whole_mag > SUM_W'(32767)) ? 16'sh7FFF : $signed(whole_mag[15:0]);
    end
  end

  // Buttons, hold timers and scroll pacing.
  always_comb begin
    a_i = in_q.button_a;
    b_i = in_q.button_b;
    trig = (in_q.right_trigger > 8'd127);
    a_prev = prev_q[2];
    b_prev = prev_q[3];
    long_b_old = is_long(hold_b_q, fr_eff);
    hold_a_base = (long_b_old && !a_prev) ? hold_b_q : hold_a_q;
    hold_a_d = a_i ? inc_sat(hold_a_base) : 16'd0;
    long_a = is_long(hold_a_d, fr_eff);
    if (b_i) begin
      hold_b_d = (long_a && !b_prev) ? hold_a_d : inc_sat(hold_b_q);
    end else begin
      hold_b_d = 16'd0;
    end
    long_b = is_long(hold_b_d, fr_eff);
    n_sat = (n_q > 32'd63) ? 6'd63 : n_q[5:0];
    down_sum = {6'd0, a_i && !a_prev};
    up_sum = {6'd0, b_i && !b_prev};
    if (long_a || long_b) begin
      st_d = strem_q + div_quo[31:0];
      if (a_i && !b_i) begin
        down_sum = down_sum + {1'b0, n_sat};
      end else if (!a_i && b_i) begin
        up_sum = up_sum + {1'b0, n_sat};
      end
    end else begin
      st_d = period_q;
    end
    res.move_x = mx_q;
    res.move_y = my_q;
    res.left_event = edge_code(in_q.right_bumper, prev_q[0]);
    res.right_event = edge_code(trig, prev_q[1]);
    res.middle_event = edge_code(in_q.button_y, prev_q[4]);
    res.scroll_down_count = (down_sum > 7'd63) ? 6'd63 : down_sum[5:0];
    res.scroll_up_count = (up_sum > 7'd63) ? 6'd63 : up_sum[5:0];
  end

  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    div_pend_d = div_pend_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_MULX;
      ST_MULX: state_d = ST_DIVX;
      ST_ACCX: state_d = ST_MULY;
      ST_MULY: state_d = ST_DIVY;
      ST_ACCY: state_d = ST_DIVP;
      ST_DIVX, ST_DIVY, ST_DIVP, ST_DIVS, ST_DIVF: begin
        if (!div_pend_q) begin
          div_start = 1'b1;
          div_pend_d = 1'b1;
        end else if (div_done) begin
          div_pend_d = 1'b0;
          case (state_q)
            ST_DIVX: state_d = ST_ACCX;
            ST_DIVY: state_d = ST_ACCY;
            ST_DIVP: state_d = ST_DIVS;
            ST_DIVS: state_d = ST_DIVF;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      div_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      div_pend_q <= div_pend_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= SENS_RESET;
      fr_q <= FRAME_RATE_RESET;
      msr_q <= SCROLL_RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SENSITIVITY:     sens_q <= cfg_data_i;
        REG_FRAME_RATE:      fr_q <= cfg_data_i[9:0];
        REG_MAX_SCROLL_RATE: msr_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Frame state kept from word to word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
      prev_q <= '0;
      hold_a_q <= '0;
      hold_b_q <= '0;
      st_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_ACCX && dz_q) acc_x_q <= acc_new;
      if (state_q == ST_ACCY && dz_q) acc_y_q <= acc_new;
      if (fin_go) begin
        prev_q <= {in_q.button_y, in_q.button_b, in_q.button_a, trig, in_q.right_bumper};
        hold_a_q <= hold_a_d;
        hold_b_q <= hold_b_d;
        st_q <= st_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
      xmag_q <= in_data_i.stick_x[15] ? 17'(-$signed({1'b1, in_data_i.stick_x}))
                                       : {1'b0, in_data_i.stick_x};
      ymag_q <= in_data_i.stick_y[15] ? 17'(-$signed({1'b1, in_data_i.stick_y}))
                                       : {1'b0, in_data_i.stick_y};
      xneg_q <= in_data_i.stick_x[15];
      // The Y axis is inverted, so a positive stick value moves up.
      yneg_q <= !in_data_i.stick_y[15] && (in_data_i.stick_y != 16'sd0);
    end
    case (state_q)
      ST_SQX, ST_MULX, ST_MULY: prod_q <= mul_p;
      ST_SQY: dz_q <= ({1'b0, prod_q} + {1'b0, mul_p}) >= {3'd0, DEADZONE_SQ};
      ST_ACCX: mx_q <= dz_q ? whole_sat : 16'sd0;
      ST_ACCY: my_q <= dz_q ? whole_sat : 16'sd0;
      ST_DIVP: if (div_done) period_q <= div_quo[31:0];
      ST_DIVS: begin
        if (div_done) begin
          n_q <= div_quo[31:0];
          strem_q <= div_rem;
        end
      end
      default: ;
    endcase
    if (fin_go) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

/* hw/rtl/gtm_checker.sv */
// Port checker for the gamepad-to-mouse mapper and its bind to the top level.
`timescale 1ns / 1ps
module gtm_port_checker
  import gtm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  // After an input word is taken the block is busy and stalls new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon");

  // A new result only comes out of a busy sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without work in progress");

endmodule

bind gamepad_to_mouse_frame_mapper_unit gtm_port_checker u_gtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/gtm_checker.sv */
// Checker for the gamepad-to-mouse mapper: mirrors registers, predicts reports and compares.
`timescale 1ns / 1ps
module gtm_checker
  import gtm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);

  localparam longint ONE = longint'(1) << FRACTION_BITS;

  logic [15:0] sens_q;
  logic [9:0]  fr_q;
  logic [9:0]  msr_q;

  longint      acc_x, acc_y;
  logic [4:0]  last_btn;
  int unsigned hold_a, hold_b, budget_ns;
  int          errors_q = 0;

  out_word_t   report_q[$];

  assign pending_o = report_q.size();
  assign errors_o = errors_q;

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [1:0] change(logic now, logic was);
    if (now == was) return EV_NONE;
    return now ? EV_PRESS : EV_RELEASE;
  endfunction

  // Adds one frame of deflection to the accumulator and returns the whole pixels taken out.
  function automatic longint step_axis(ref longint acc, input longint s, input longint fr);
    longint stp, sum, whole;
    stp = (s * longint'(sens_q) * ONE) / (longint'(32767) * fr);
    sum = acc + stp;
    whole = sum / ONE;
    acc = sum - whole * ONE;
    return whole;
  endfunction

  task automatic predict_report(input in_word_t w);
    out_word_t   r;
    longint      x, y, mx, my;
    logic        trig, a, b, a_was, b_was;
    int unsigned fr, msr, down, up, period, n;
    x = w.stick_x;
    y = w.stick_y;
    trig = w.right_trigger > 8'd127;
    a = w.button_a;
    b = w.button_b;
    a_was = last_btn[2];
    b_was = last_btn[3];
    fr = (fr_q == 0) ? 1 : fr_q;
    msr = (msr_q == 0) ? 1 : msr_q;
    down = 0;
    up = 0;
    mx = 0;
    my = 0;
    if (x * x + y * y >= longint'(DEADZONE_SQ)) begin
      mx = step_axis(acc_x, x, fr);
      my = step_axis(acc_y, -y, fr);
    end
    r.left_event = change(w.right_bumper, last_btn[0]);
    r.right_event = change(trig, last_btn[1]);
    r.middle_event = change(w.button_y, last_btn[4]);
    // A long hold on one button carries over to the other when it is pressed.
    if (a) begin
      if (5 * hold_b > 3 * fr && !a_was) hold_a = hold_b;
      hold_a = (hold_a < 65535) ? hold_a + 1 : 65535;
      if (!a_was) down++;
    end else begin
      hold_a = 0;
    end
    if (b) begin
      if (5 * hold_a > 3 * fr && !b_was) hold_b = hold_a;
      else hold_b = (hold_b < 65535) ? hold_b + 1 : 65535;
      if (!b_was) up++;
    end else begin
      hold_b = 0;
    end
    period = NS_PER_S / msr;
    if (5 * hold_a > 3 * fr || 5 * hold_b > 3 * fr) begin
      if (budget_ns >= period) begin
        n = budget_ns / period;
        budget_ns -= n * period;
        if (a && !b) down += (n > 63) ? 63 : n;
        else if (b && !a) up += (n > 63) ? 63 : n;
      end
      budget_ns += NS_PER_S / fr;
    end else begin
      budget_ns = period;
    end
    last_btn = {w.button_y, b, a, trig, w.right_bumper};
    r.move_x = clamp16(mx);
    r.move_y = clamp16(my);
    r.scroll_down_count = (down > 63) ? 63 : down;
    r.scroll_up_count = (up > 63) ? 63 : up;
    report_q.push_back(r);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errors_q++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      sens_q <= SENS_RESET;
      fr_q <= FRAME_RATE_RESET;
      msr_q <= SCROLL_RATE_RESET;
      acc_x = 0;
      acc_y = 0;
      last_btn = '0;
      hold_a = 0;
      hold_b = 0;
      budget_ns = 0;
      report_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $display("%0t: report with none expected, got %p", $time, out_data_i);
          errors_q++;
        end else begin
          e = report_q.pop_front();
          check_field("move_x", e.move_x, out_data_i.move_x);
          check_field("move_y", e.move_y, out_data_i.move_y);
          check_field("left_event", e.left_event, out_data_i.left_event);
          check_field("right_event", e.right_event, out_data_i.right_event);
          check_field("middle_event", e.middle_event, out_data_i.middle_event);
          check_field("scroll_down", e.scroll_down_count, out_data_i.scroll_down_count);
          check_field("scroll_up", e.scroll_up_count, out_data_i.scroll_up_count);
        end
      end
      if (in_valid_i && !in_stall_i) predict_report(in_data_i);
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SENSITIVITY:     sens_q <= cfg_data_i;
          REG_FRAME_RATE:      fr_q <= cfg_data_i[9:0];
          REG_MAX_SCROLL_RATE: msr_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the gamepad-to-mouse mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import gtm_pkg::*;

  logic       clk, rst_n;
  logic       in_valid, in_stall, out_valid, out_stall;
  in_word_t   in_data;
  out_word_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [15:0] cfg_data;
  int         errors, pending;
  logic       btn_a, btn_b, btn_y, bump;
  logic [7:0] trig;

  gamepad_to_mouse_frame_mapper_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  gtm_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("gamepad_to_mouse_frame_mapper_unit: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(20, 300);
  endfunction

  // Receiver: random stalls, with one long hold-off so the block backs up.
  initial begin
    int cyc;
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 300) begin
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
      end
      if ((cyc / 5000) % 3 == 2) begin
        out_stall = 1'b0;
      end else begin
        n = pick_gap();
        out_stall = (n != 0);
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      in_data = in_word_t'($bits(in_word_t)'({$urandom, $urandom}));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic pad(int x, int y, logic bp, logic [7:0] tr, logic a, logic b, logic yb);
    in_word_t w;
    w.stick_x = x[15:0];
    w.stick_y = y[15:0];
    w.right_bumper = bp;
    w.right_trigger = tr;
    w.button_a = a;
    w.button_b = b;
    w.button_y = yb;
    send_word(w);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = 16'($urandom);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] s, logic [15:0] f, logic [15:0] m);
    drain();
    write_reg(REG_SENSITIVITY, s);
    write_reg(REG_FRAME_RATE, f);
    write_reg(REG_MAX_SCROLL_RATE, m);
  endtask

  // Buttons mostly stay put for long runs so holds reach auto-repeat.
  task automatic random_frames(int count);
    int x, y;
    repeat (count) begin
      if ($urandom_range(0, 30) == 0) btn_a = ~btn_a;
      if ($urandom_range(0, 30) == 0) btn_b = ~btn_b;
      if ($urandom_range(0, 15) == 0) btn_y = ~btn_y;
      if ($urandom_range(0, 15) == 0) bump = ~bump;
      if ($urandom_range(0, 15) == 0) trig = 8'($urandom);
      case ($urandom_range(0, 3))
        0: begin x = $urandom_range(0, 7000) - 3500; y = $urandom_range(0, 7000) - 3500; end
        1: begin x = $urandom_range(0, 1) ? 32767 : -32768; y = $urandom_range(0, 65535) - 32768; end
        default: begin x = $urandom_range(0, 65535) - 32768; y = $urandom_range(0, 65535) - 32768; end
      endcase
      if ($urandom_range(0, 19) == 0)
        pad(x, y, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      else
        pad(x, y, bump, trig, btn_a, btn_b, btn_y);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_SENSITIVITY;
    cfg_data = '0;
    btn_a = 0; btn_b = 0; btn_y = 0; bump = 0; trig = 0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at reset settings.
    pad(0, 0, 0, 0, 0, 0, 0);
    pad(32767, 32767, 1, 8'd128, 0, 0, 1);
    pad(-32768, -32768, 0, 8'd127, 0, 0, 0);
    pad(4915, 0, 1, 8'd255, 0, 0, 0);
    pad(4914, 0, 0, 8'd0, 0, 0, 0);
    pad(0, 4916, 0, 0, 0, 0, 0);
    pad(3476, -3476, 0, 0, 0, 0, 0);
    pad(1, -1, 0, 0, 1, 0, 0);
    repeat (100) pad(0, 0, 0, 0, 1, 0, 0);
    pad(0, 0, 0, 0, 1, 1, 0);
    pad(0, 0, 0, 0, 0, 1, 0);
    repeat (3) pad(0, 0, 0, 0, 0, 1, 0);
    pad(0, 0, 0, 0, 0, 0, 0);

    // Extremes, including zero rates that count as one and saturated motion.
    set_regs(16'hffff, 16'h0000, 16'h0000);
    pad(32767, -32768, 0, 0, 1, 0, 0);
    repeat (4) pad(-32768, 32767, 0, 0, 1, 0, 0);
    pad(0, 0, 0, 0, 0, 0, 0);
    set_regs(16'hffff, 16'hfc01, 16'h03e8);
    repeat (20) pad(0, 0, 0, 0, 1, 0, 0);
    pad(0, 0, 0, 0, 1, 1, 0);
    pad(0, 0, 0, 0, 0, 0, 0);

    set_regs(16'd1200, 16'd144, 16'd20);
    random_frames(100);
    set_regs(16'd0, 16'd1000, 16'd1);
    random_frames(40);
    set_regs(16'hffff, 16'd1, 16'd1000);
    random_frames(60);
    set_regs(16'($urandom), 16'($urandom_range(1, 1023)), 16'hffff);
    random_frames(60);
    set_regs(16'($urandom), 16'd10, 16'($urandom_range(1, 1000)));
    random_frames(100);

    drain();
    if (errors == 0)
      $display("gamepad_to_mouse_frame_mapper_unit: match");
    else
      $display("gamepad_to_mouse_frame_mapper_unit: mismatch");
    $finish;
  end

endmodule
